>>> hdl/pnti_pkg.sv
package pnti_pkg;

	// Q4.12 fixed point
	localparam int Q_SHIFT = 12;
	localparam int Q_ONE   = 4096;

	// fixed field widths
	localparam int OP_BITS    = 2;
	localparam int INDEX_BITS = 8;
	localparam int RATE_BITS  = 15;
	localparam int MODE_BITS  = 2;

	// configuration channel
	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 16;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LEARNING_RATE   = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ACTIVATION_MODE = 4'd1;

	// activation modes; any other code behaves as linear
	localparam logic [MODE_BITS-1:0] MODE_LINEAR   = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_STEP     = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_BIPOLAR  = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_RESERVED = 2'd3;

	localparam logic [RATE_BITS-1:0] RATE_RESET = 15'd410;
	localparam logic [MODE_BITS-1:0] MODE_RESET = MODE_STEP;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [OP_BITS-1:0] {
		OP_LOAD_WEIGHT = 2'd0,
		OP_LOAD_BIAS   = 2'd1,
		OP_FORWARD     = 2'd2,
		OP_TRAIN       = 2'd3
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic                  in_range;
		logic                  last;
		logic [INDEX_BITS-1:0] index;
	} item_ctrl_t;

	typedef struct packed {
		logic [RATE_BITS-1:0] learning_rate;
		logic [MODE_BITS-1:0] activation_mode;
	} cfg_t;

endpackage

>>> hdl/pnti_item_if.sv
interface pnti_item_if #(
	parameter int VALUE_BITS = 16
);
	logic                                  valid;
	logic                                  ready;
	logic [pnti_pkg::OP_BITS-1:0]          operation;
	logic [pnti_pkg::INDEX_BITS-1:0]       element_index;
	logic signed [VALUE_BITS-1:0]          element_value;
	logic                                  last_element;
	logic signed [VALUE_BITS-1:0]          target_value;

	modport source (
		output valid, operation, element_index, element_value, last_element, target_value,
		input  ready
	);

	modport sink (
		input  valid, operation, element_index, element_value, last_element, target_value,
		output ready
	);
endinterface

>>> hdl/pnti_result_if.sv
interface pnti_result_if #(
	parameter int VALUE_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] neuron_output;
	logic signed [VALUE_BITS-1:0] weighted_sum;

	modport source (
		output valid, neuron_output, weighted_sum,
		input  ready
	);

	modport sink (
		input  valid, neuron_output, weighted_sum,
		output ready
	);
endinterface

>>> hdl/pnti_cfg_if.sv
interface pnti_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [pnti_pkg::CFG_INDEX_BITS-1:0] index;
	logic [pnti_pkg::CFG_DATA_BITS-1:0]  data;

	modport source (
		output valid, index, data,
		input  ready
	);

	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

>>> hdl/pnti_ram.sv
module pnti_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/pnti_front.sv
module pnti_front #(
	parameter int MAX_INPUTS = 256,
	parameter int VALUE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	pnti_item_if.sink                    item,
	input  logic                         pop,
	output logic                         head_valid,
	output pnti_pkg::item_ctrl_t         head_ctrl,
	output logic signed [VALUE_BITS-1:0] head_value,
	output logic signed [VALUE_BITS-1:0] head_target
);

	localparam int PTR_W = (pnti_pkg::QUEUE_DEPTH > 1) ? $clog2(pnti_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(pnti_pkg::QUEUE_DEPTH + 1);

	pnti_pkg::item_ctrl_t         ctrl_q   [pnti_pkg::QUEUE_DEPTH];
	logic signed [VALUE_BITS-1:0] value_q  [pnti_pkg::QUEUE_DEPTH];
	logic signed [VALUE_BITS-1:0] target_q [pnti_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]             wr_ptr_q;
	logic [PTR_W-1:0]             rd_ptr_q;
	logic [CNT_W-1:0]             count_q;
	logic                         push;
	pnti_pkg::item_ctrl_t         push_ctrl;

	assign item.ready = (count_q != CNT_W'(pnti_pkg::QUEUE_DEPTH));
	assign push       = item.valid && item.ready;
	assign head_valid = (count_q != '0);

	// classify the item on the way in
	always_comb begin
		push_ctrl.op       = pnti_pkg::op_t'(item.operation);
		push_ctrl.in_range = (32'(item.element_index) < 32'(MAX_INPUTS));
		push_ctrl.last     = item.last_element;
		push_ctrl.index    = item.element_index;
	end

	assign head_ctrl   = ctrl_q[rd_ptr_q];
	assign head_value  = value_q[rd_ptr_q];
	assign head_target = target_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ctrl_q[wr_ptr_q]   <= push_ctrl;
			value_q[wr_ptr_q]  <= item.element_value;
			target_q[wr_ptr_q] <= item.target_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(pnti_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(pnti_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/pnti_back.sv
module pnti_back #(
	parameter int MAX_INPUTS = 256,
	parameter int VALUE_BITS = 16,
	parameter int ACC_BITS   = 40
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pnti_pkg::cfg_t               cfg,
	input  logic                         head_valid,
	input  pnti_pkg::item_ctrl_t         head_ctrl,
	input  logic signed [VALUE_BITS-1:0] head_value,
	input  logic signed [VALUE_BITS-1:0] head_target,
	output logic                         pop,
	pnti_result_if.source                result
);

	localparam int V       = VALUE_BITS;
	localparam int QS      = pnti_pkg::Q_SHIFT;
	localparam int ADDR_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int PROD_W  = 2 * V;
	localparam int SUM_W   = ((ACC_BITS > PROD_W) ? ACC_BITS : PROD_W) + 1;
	localparam int BIAS_W  = V + QS;
	localparam int S_W     = ((ACC_BITS > BIAS_W) ? ACC_BITS : BIAS_W) + 1;
	localparam int SX_W    = (ACC_BITS > V) ? ACC_BITS : V;
	localparam int E_W     = V + 1;
	localparam int EF_W    = pnti_pkg::RATE_BITS + 1 + E_W;
	localparam int F_W     = ((EF_W - QS) < 32) ? (EF_W - QS) : 32;
	localparam int FX_W    = F_W + V;
	localparam int NW_W    = FX_W + 1;
	localparam int NB_W    = F_W + 1;

	// plus and minus one in Q4.12, saturated to the value width
	localparam logic signed [V-1:0] ONE_V =
		(V > QS + 1) ? V'(pnti_pkg::Q_ONE) : V'((64'sd1 <<< (V - 1)) - 64'sd1);
	localparam logic signed [V-1:0] MINUS_ONE_V =
		(V > QS + 1) ? V'(-pnti_pkg::Q_ONE) : V'(-(64'sd1 <<< (V - 1)));

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_MUL     = 6'b000010,
		ST_ACC     = 6'b000100,
		ST_FIN     = 6'b001000,
		ST_TRAIN_F = 6'b010000,
		ST_TRAIN_W = 6'b100000
	} state_t;

	state_t                       state_q, state_d;
	pnti_pkg::item_ctrl_t         ctrl_q;
	logic signed [V-1:0]          x_q;
	logic signed [ACC_BITS-1:0]   acc_q;
	logic signed [V-1:0]          bias_q;
	logic signed [V-1:0]          last_out_q;
	logic signed [PROD_W-1:0]     prod_q;
	logic signed [EF_W-1:0]       ef_q;
	logic signed [FX_W-1:0]       fx_q;
	logic                         res_valid_q;
	logic signed [V-1:0]          res_out_q;
	logic signed [V-1:0]          res_sum_q;

	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_waddr;
	logic [V-1:0]                 ram_wdata;
	logic                         ram_re;
	logic [V-1:0]                 w_rd;
	logic signed [V-1:0]          w_eff;

	logic signed [PROD_W-1:0]     prod_d;
	logic signed [SUM_W-1:0]      acc_sum;
	logic signed [ACC_BITS-1:0]   acc_next;
	logic signed [S_W-1:0]        s_sum;
	logic signed [ACC_BITS-1:0]   s_val;
	logic                         s_pos;
	logic signed [SX_W-1:0]       ws_wide;
	logic signed [V-1:0]          ws_val;
	logic signed [V-1:0]          y_val;
	logic                         fin_go;

	logic signed [E_W-1:0]        err;
	logic signed [EF_W-1:0]       ef_d;
	logic signed [EF_W-1:0]       ef_sh;
	logic signed [F_W-1:0]        f_val;
	logic signed [FX_W-1:0]       fx_d;
	logic signed [NB_W-1:0]       nb_sum;
	logic signed [V-1:0]          nb_val;
	logic signed [FX_W-1:0]       dw;
	logic signed [NW_W-1:0]       nw_sum;
	logic signed [V-1:0]          nw_val;

	pnti_ram #(
		.WIDTH (V),
		.DEPTH (MAX_INPUTS)
	) u_weights (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ADDR_W'(head_ctrl.index)),
		.rdata (w_rd)
	);

	assign pop    = (state_q == ST_IDLE) && head_valid;
	assign ram_re = pop;
	assign fin_go = !res_valid_q || result.ready;

	// weight writes: a load from the queue head, or a training update
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ADDR_W'(head_ctrl.index);
		ram_wdata = head_value;
		if (state_q == ST_TRAIN_W) begin
			ram_we    = ctrl_q.in_range;
			ram_waddr = ADDR_W'(ctrl_q.index);
			ram_wdata = nw_val;
		end else if (pop && head_ctrl.op == pnti_pkg::OP_LOAD_WEIGHT) begin
			ram_we = head_ctrl.in_range;
		end
	end

	// forward datapath
	assign w_eff   = ctrl_q.in_range ? $signed(w_rd) : '0;
	assign prod_d  = w_eff * x_q;
	assign acc_sum = SUM_W'(acc_q) + SUM_W'(prod_q);

	always_comb begin
		if (&acc_sum[SUM_W-1:ACC_BITS-1] || !(|acc_sum[SUM_W-1:ACC_BITS-1])) begin
			acc_next = acc_sum[ACC_BITS-1:0];
		end else begin
			acc_next = {acc_sum[SUM_W-1], {(ACC_BITS-1){!acc_sum[SUM_W-1]}}};
		end
	end

	assign s_sum = S_W'(acc_q) + S_W'($signed({bias_q, {QS{1'b0}}}));

	always_comb begin
		if (&s_sum[S_W-1:ACC_BITS-1] || !(|s_sum[S_W-1:ACC_BITS-1])) begin
			s_val = s_sum[ACC_BITS-1:0];
		end else begin
			s_val = {s_sum[S_W-1], {(ACC_BITS-1){!s_sum[S_W-1]}}};
		end
	end

	assign s_pos   = !s_val[ACC_BITS-1] && (|s_val);
	assign ws_wide = SX_W'(s_val) >>> QS;

	always_comb begin
		if (&ws_wide[SX_W-1:V-1] || !(|ws_wide[SX_W-1:V-1])) begin
			ws_val = ws_wide[V-1:0];
		end else begin
			ws_val = {ws_wide[SX_W-1], {(V-1){!ws_wide[SX_W-1]}}};
		end
	end

	always_comb begin
		unique case (cfg.activation_mode)
			pnti_pkg::MODE_STEP:    y_val = s_pos ? ONE_V : '0;
			pnti_pkg::MODE_BIPOLAR: y_val = s_pos ? ONE_V : MINUS_ONE_V;
			default:                y_val = ws_val;
		endcase
	end

	// training datapath
	assign err  = E_W'(head_target) - E_W'(last_out_q);
	assign ef_d = $signed({1'b0, cfg.learning_rate}) * err;
	assign ef_sh = ef_q >>> QS;

	always_comb begin
		if (&ef_sh[EF_W-1:F_W-1] || !(|ef_sh[EF_W-1:F_W-1])) begin
			f_val = ef_sh[F_W-1:0];
		end else begin
			f_val = {ef_sh[EF_W-1], {(F_W-1){!ef_sh[EF_W-1]}}};
		end
	end

	assign fx_d   = f_val * x_q;
	assign nb_sum = NB_W'(bias_q) + NB_W'(f_val);

	always_comb begin
		if (&nb_sum[NB_W-1:V-1] || !(|nb_sum[NB_W-1:V-1])) begin
			nb_val = nb_sum[V-1:0];
		end else begin
			nb_val = {nb_sum[NB_W-1], {(V-1){!nb_sum[NB_W-1]}}};
		end
	end

	assign dw     = fx_q >>> QS;
	assign nw_sum = NW_W'($signed(w_rd)) + NW_W'(dw);

	always_comb begin
		if (&nw_sum[NW_W-1:V-1] || !(|nw_sum[NW_W-1:V-1])) begin
			nw_val = nw_sum[V-1:0];
		end else begin
			nw_val = {nw_sum[NW_W-1], {(V-1){!nw_sum[NW_W-1]}}};
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					unique case (head_ctrl.op)
						pnti_pkg::OP_LOAD_WEIGHT: state_d = ST_IDLE;
						pnti_pkg::OP_LOAD_BIAS:   state_d = ST_IDLE;
						pnti_pkg::OP_FORWARD:     state_d = ST_MUL;
						pnti_pkg::OP_TRAIN:       state_d = ST_TRAIN_F;
					endcase
				end
			end
			ST_MUL:     state_d = ST_ACC;
			ST_ACC:     state_d = ctrl_q.last ? ST_FIN : ST_IDLE;
			ST_FIN:     state_d = fin_go ? ST_IDLE : ST_FIN;
			ST_TRAIN_F: state_d = ST_TRAIN_W;
			ST_TRAIN_W: state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			ctrl_q <= head_ctrl;
			x_q    <= head_value;
			ef_q   <= ef_d;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_d;
		end
		if (state_q == ST_TRAIN_F) begin
			fx_q <= fx_d;
		end
		if (state_q == ST_FIN && fin_go) begin
			res_out_q <= y_val;
			res_sum_q <= ws_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			bias_q      <= '0;
			last_out_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && head_ctrl.op == pnti_pkg::OP_LOAD_BIAS) begin
				bias_q <= head_value;
			end
			if (state_q == ST_TRAIN_F && ctrl_q.last) begin
				bias_q <= nb_val;
			end
			if (state_q == ST_ACC) begin
				acc_q <= acc_next;
			end
			if (state_q == ST_FIN && fin_go) begin
				acc_q       <= '0;
				last_out_q  <= y_val;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid         = res_valid_q;
	assign result.neuron_output = res_out_q;
	assign result.weighted_sum  = res_sum_q;

endmodule

>>> hdl/perceptron_neuron_train_infer_core.sv
// Single perceptron neuron in Q4.12 fixed point with inference and training by the
// perceptron learning rule. Items enter on the item channel: a load writes one weight
// or the bias, a forward element adds weight*x to a saturating accumulator and, on the
// last element, adds the bias, applies the activation and transfers one result; a train
// element applies w += eta*(d - y)*x, and on the last element also updates the bias.
// A two-entry queue separates the intake from the sequencer, so the item channel keeps
// taking transfers while there is room, also while an element is worked on or a result
// waits. The sequencer runs one item at a time: a forward element runs weight RAM read,
// multiply, accumulate and, on the last element, bias and activation; a train element
// runs error times rate, times x, weight write back. A held result stalls only the final
// forward step. No clearing pass runs after reset; a weight must be loaded before it is
// used. Configuration registers must be written only while idle; this is not enforced.
module perceptron_neuron_train_infer_core #(
	parameter int MAX_INPUTS = 256,
	parameter int VALUE_BITS = 16,
	parameter int ACC_BITS   = 40
) (
	input  logic            clk,
	input  logic            arst_n,
	pnti_item_if.sink       item,
	pnti_result_if.source   result,
	pnti_cfg_if.sink        cfg
);

	pnti_pkg::cfg_t               cfg_q;
	logic                         head_valid;
	pnti_pkg::item_ctrl_t         head_ctrl;
	logic signed [VALUE_BITS-1:0] head_value;
	logic signed [VALUE_BITS-1:0] head_target;
	logic                         pop;

	// configuration writes always complete in one transfer
	assign cfg.ready = 1'b1;

	// hold the learning rate and activation mode; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learning_rate   <= pnti_pkg::RATE_RESET;
			cfg_q.activation_mode <= pnti_pkg::MODE_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == pnti_pkg::CFG_LEARNING_RATE) begin
				cfg_q.learning_rate <= cfg.data[pnti_pkg::RATE_BITS-1:0];
			end
			if (cfg.index == pnti_pkg::CFG_ACTIVATION_MODE) begin
				cfg_q.activation_mode <= cfg.data[pnti_pkg::MODE_BITS-1:0];
			end
		end
	end

	// intake: classify items and queue them
	pnti_front #(
		.MAX_INPUTS (MAX_INPUTS),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.pop         (pop),
		.head_valid  (head_valid),
		.head_ctrl   (head_ctrl),
		.head_value  (head_value),
		.head_target (head_target)
	);

	// sequencer: weight RAM, accumulator, activation and training updates
	pnti_back #(
		.MAX_INPUTS (MAX_INPUTS),
		.VALUE_BITS (VALUE_BITS),
		.ACC_BITS   (ACC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head_valid  (head_valid),
		.head_ctrl   (head_ctrl),
		.head_value  (head_value),
		.head_target (head_target),
		.pop         (pop),
		.result      (result)
	);

endmodule
